### hdl/deq_pkg.sv
package deq_pkg;

    // Default sizes of the store.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int STS_W   = 2;
    localparam int NUM_W   = 5;

    // Operation codes carried by the mode field.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;
        logic exec;
        logic scan_step;
        logic rd_head;
        logic rd_tail;
        logic load_out;
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_go;
        logic scan_done;
        logic out_free;
    } deq_sts_t;

endpackage

### hdl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_sts_t sts,
    output deq_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXEC    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_RD_HEAD = 6'b001000,
        ST_RD_TAIL = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and the commands issued in each state.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.search_go ? ST_SCAN : ST_RD_HEAD;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_RD_HEAD;
                end
            end
            ST_RD_HEAD: begin
                cmd.rd_head = 1'b1;
                state_next  = ST_RD_TAIL;
            end
            ST_RD_TAIL: begin
                cmd.rd_tail = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  deq_cmd_t                  cmd,
    output deq_sts_t                  sts,
    input  logic        [MODE_W-1:0]  s_mode,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [STS_W-1:0]   m_status,
    output logic                      m_found,
    output logic        [NUM_W-1:0]   m_position,
    output logic        [NUM_W-1:0]   m_count,
    output logic signed [VALUE_W-1:0] m_head_value,
    output logic signed [VALUE_W-1:0] m_tail_value,
    output logic                      m_is_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int WIDE_W = CNT_W + NUM_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W:0]   SUM_LIM  = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // Ring store and its single read port.
    logic [DATA_WIDTH-1:0] entries_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [MODE_W-1:0]     mode_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [PTR_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [STS_W-1:0]      status_reg, status_next;
    logic                  found_reg, found_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [PTR_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [DATA_WIDTH-1:0] head_reg;
    logic                  out_valid_reg;

    logic signed [EXT_W-1:0] val_ext;
    logic [PTR_W-1:0]        front_dec;
    logic [PTR_W-1:0]        offset;
    logic [PTR_W:0]          slot_sum;
    logic [PTR_W-1:0]        slot_addr;
    logic                    cnt_zero;
    logic                    cnt_full;
    logic                    hit;
    logic                    scan_last;
    logic                    mem_we;
    logic [PTR_W-1:0]        wr_addr;
    logic                    rd_en;
    logic signed [EXT_W-1:0] head_ext;
    logic signed [EXT_W-1:0] tail_ext;
    logic [WIDE_W-1:0]       pos_wide;
    logic [WIDE_W-1:0]       cnt_wide;

    // Input word in stored form: sign-extended, then cut to the store width.
    assign val_ext = EXT_W'(s_value);

    assign cnt_zero  = (count_reg == '0);
    assign cnt_full  = (count_reg == CNT_FULL);
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - PTR_W'(1);
    assign hit       = (rd_data_reg == key_reg);
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    // Ring offset for the one address computed this cycle.
    always_comb begin
        offset = '0;
        if (cmd.exec) begin
            case (mode_reg)
                MODE_PUSH_BACK: offset = count_reg[PTR_W-1:0];
                MODE_POP_FRONT: offset = PTR_W'(1);
                default:        offset = '0;
            endcase
        end else if (cmd.scan_step) begin
            offset = scan_idx_reg + PTR_W'(1);
        end else if (cmd.rd_tail && !cnt_zero) begin
            offset = PTR_W'(count_reg - CNT_W'(1));
        end
    end

    // Front plus offset, wrapped once around the ring.
    assign slot_sum  = {1'b0, front_reg} + {1'b0, offset};
    assign slot_addr = (slot_sum >= SUM_LIM) ? PTR_W'(slot_sum - SUM_LIM)
                                             : slot_sum[PTR_W-1:0];

    // Operation step and search step.
    always_comb begin
        front_next    = front_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        scan_idx_next = scan_idx_reg;
        mem_we        = 1'b0;
        wr_addr       = slot_addr;
        if (cmd.exec) begin
            status_next   = STS_OK;
            found_next    = 1'b0;
            pos_next      = '0;
            scan_idx_next = '0;
            case (mode_reg)
                MODE_PUSH_FRONT: begin
                    if (cnt_full) begin
                        status_next = STS_FULL;
                    end else begin
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                        mem_we     = 1'b1;
                        wr_addr    = front_dec;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (cnt_full) begin
                        status_next = STS_FULL;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        mem_we     = 1'b1;
                    end
                end
                MODE_POP_FRONT: begin
                    if (cnt_zero) begin
                        status_next = STS_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        front_next = (count_reg == CNT_W'(1)) ? '0 : slot_addr;
                    end
                end
                MODE_POP_BACK: begin
                    if (cnt_zero) begin
                        status_next = STS_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1)) begin
                            front_next = '0;
                        end
                    end
                end
                MODE_CLEAR: begin
                    count_next = '0;
                    front_next = '0;
                end
                default: begin
                end
            endcase
        end else if (cmd.scan_step) begin
            if (hit) begin
                found_next = 1'b1;
                pos_next   = CNT_W'(scan_idx_reg) + CNT_W'(1);
            end else if (!scan_last) begin
                scan_idx_next = scan_idx_reg + PTR_W'(1);
            end
        end
    end

    // Search reads go only to live entries; the head and tail reads are issued even when the queue is empty.
    assign rd_en = (cmd.exec && (mode_reg == MODE_SEARCH) && !cnt_zero)
                 || (cmd.scan_step && !hit && !scan_last)
                 || cmd.rd_head || cmd.rd_tail;

    assign sts.search_go = (mode_reg == MODE_SEARCH) && !cnt_zero;
    assign sts.scan_done = hit || scan_last;
    assign sts.out_free  = !out_valid_reg || m_ready;

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entries_mem[wr_addr] <= key_reg;
        end
        if (rd_en) begin
            rd_data_reg <= entries_mem[slot_addr];
        end
    end

    // Queue pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Latched request and per-operation results.
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            mode_reg <= s_mode;
            key_reg  <= val_ext[DATA_WIDTH-1:0];
        end
        if (cmd.rd_tail) begin
            head_reg <= rd_data_reg;
        end
        status_reg   <= status_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        scan_idx_reg <= scan_idx_next;
    end

    // Stored words are read back sign-extended.
    assign head_ext = EXT_W'($signed(head_reg));
    assign tail_ext = EXT_W'($signed(rd_data_reg));
    assign pos_wide = WIDE_W'(pos_reg);
    assign cnt_wide = WIDE_W'(count_reg);

    // Output register: the result word waits here until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status     <= status_reg;
            m_found      <= found_reg;
            m_position   <= pos_wide[NUM_W-1:0];
            m_count      <= cnt_wide[NUM_W-1:0];
            m_head_value <= cnt_zero ? '0 : head_ext[VALUE_W-1:0];
            m_tail_value <= cnt_zero ? '0 : tail_ext[VALUE_W-1:0];
            m_is_empty   <= cnt_zero;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

### hdl/double_ended_queue_with_search.sv
// Channel   Ports                                             Direction
// --------  ------------------------------------------------  ---------
// input     s_valid s_ready s_mode s_value                    in
// result    m_valid m_ready m_status m_found m_position       out
//           m_count m_head_value m_tail_value m_is_empty
//
// Push, pop, clear: the accepted word steps through EXEC, RD_HEAD, RD_TAIL and DONE.
// Search: SCAN comes between EXEC and RD_HEAD and compares one stored word per
// cycle through the single read port of the ring store, until a hit or the last entry.
// Reset (aresetn low, synchronous) empties the queue; the store needs no clearing pass.
// A result word waits in the output register; the next input word is taken
// meanwhile, and the result stage holds only while that register is still full.
module double_ended_queue_with_search
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic        [MODE_W-1:0]  s_mode,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [STS_W-1:0]   m_status,
    output logic                      m_found,
    output logic        [NUM_W-1:0]   m_position,
    output logic        [NUM_W-1:0]   m_count,
    output logic signed [VALUE_W-1:0] m_head_value,
    output logic signed [VALUE_W-1:0] m_tail_value,
    output logic                      m_is_empty
);

    deq_cmd_t cmd;
    deq_sts_t sts;

    // Operation sequencer.
    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Ring store, pointers and output register.
    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_count      (m_count),
        .m_head_value (m_head_value),
        .m_tail_value (m_tail_value),
        .m_is_empty   (m_is_empty)
    );

`ifndef ASSERT_OFF
    // One word is worked on at a time: no accept right after an accept.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous word still in work");

    // The sequencer issues at most one command per cycle.
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take_in, cmd.exec, cmd.scan_step, cmd.rd_head, cmd.rd_tail,
                  cmd.load_out}))
        else $error("more than one command issued");

    // The output register is never overwritten while a word still waits.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending word");

    // A failed push or pop never reports a search hit.
    a_status_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STS_OK)) |-> !m_found)
        else $error("found flag set on a failed operation");
`endif

endmodule

### sim/double_ended_queue_with_search_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_with_search_tb
    import deq_pkg::*;
;

    localparam int RANDOM_WORDS = 1700;
    localparam int PHASE_WORDS  = 300;
    localparam int MAX_GAP      = 19;
    localparam int SETTLE_CYCLES = 40;

    // The two mode codes that the block treats as no operation.
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // One result word as the block should present it.
    typedef struct packed {
        logic [STS_W-1:0]          status;
        logic                      found;
        logic [NUM_W-1:0]          position;
        logic [NUM_W-1:0]          count;
        logic signed [VALUE_W-1:0] head;
        logic signed [VALUE_W-1:0] tail;
        logic                      is_empty;
    } deque_outcome_t;

    // Mirror of the deque, with the outcomes still owed by the block.
    class deque_scoreboard;
        logic signed [VALUE_W-1:0] ring [DEPTH_DEF];
        int front_ptr;
        int fill;
        deque_outcome_t owed[$];
        int errors;
        int words_checked;
        int full_pushes;
        int empty_pops;
        int search_hits;
        int peak_fill;

        function new();
            front_ptr = 0;
            fill = 0;
            errors = 0;
            words_checked = 0;
            full_pushes = 0;
            empty_pops = 0;
            search_hits = 0;
            peak_fill = 0;
        endfunction

        function int slot(int offset);
            return (front_ptr + offset) % DEPTH_DEF;
        endfunction

        function logic signed [VALUE_W-1:0] entry_at(int pos);
            return ring[slot(pos)];
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // Apply one operation to the mirror and return what the block must report.
        function deque_outcome_t apply_op(logic [MODE_W-1:0] mode,
                                          logic signed [VALUE_W-1:0] value);
            deque_outcome_t r;
            r = '0;
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (fill >= DEPTH_DEF) begin
                        r.status = STS_FULL;
                    end else begin
                        front_ptr = (front_ptr + DEPTH_DEF - 1) % DEPTH_DEF;
                        ring[front_ptr] = value;
                        fill++;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (fill >= DEPTH_DEF) begin
                        r.status = STS_FULL;
                    end else begin
                        ring[slot(fill)] = value;
                        fill++;
                    end
                end
                MODE_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        front_ptr = slot(1);
                        fill--;
                        if (fill == 0) front_ptr = 0;
                    end
                end
                MODE_POP_BACK: begin
                    if (fill == 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        fill--;
                        if (fill == 0) front_ptr = 0;
                    end
                end
                MODE_SEARCH: begin
                    // Only the first match from the front counts.
                    for (int i = 0; i < fill; i++) begin
                        if (!r.found && ring[slot(i)] == value) begin
                            r.found = 1'b1;
                            r.position = NUM_W'(i + 1);
                        end
                    end
                end
                MODE_CLEAR: begin
                    fill = 0;
                    front_ptr = 0;
                end
                default: begin
                end
            endcase
            r.count = NUM_W'(fill);
            if (fill == 0) begin
                r.is_empty = 1'b1;
            end else begin
                r.head = ring[slot(0)];
                r.tail = ring[slot(fill - 1)];
            end
            return r;
        endfunction

        // An input word was accepted by the block.
        function void note_word(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value);
            deque_outcome_t r;
            r = apply_op(mode, value);
            owed.push_back(r);
            if (r.status == STS_FULL) full_pushes++;
            if (r.status == STS_EMPTY) empty_pops++;
            if (r.found) search_hits++;
            if (fill > peak_fill) peak_fill = fill;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("ERROR at %0t ns: %s is %0d, should be %0d", $time, what, got, want);
            errors++;
        endtask

        // A result word was accepted from the block.
        task check_word(deque_outcome_t got);
            deque_outcome_t want;
            words_checked++;
            if (owed.size() == 0) begin
                report_mismatch("result word with nothing owed, count", got.count, 0);
            end else begin
                want = owed.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.position !== want.position)
                    report_mismatch("position", got.position, want.position);
                if (got.count !== want.count)
                    report_mismatch("count", got.count, want.count);
                if (got.head !== want.head)
                    report_mismatch("head_value", got.head, want.head);
                if (got.tail !== want.tail)
                    report_mismatch("tail_value", got.tail, want.tail);
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", got.is_empty, want.is_empty);
            end
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic        [MODE_W-1:0]  s_mode;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic        [STS_W-1:0]   m_status;
    logic                      m_found;
    logic        [NUM_W-1:0]   m_position;
    logic        [NUM_W-1:0]   m_count;
    logic signed [VALUE_W-1:0] m_head_value;
    logic signed [VALUE_W-1:0] m_tail_value;
    logic                      m_is_empty;

    deque_scoreboard deq_model = new();
    bit no_idle = 1'b0;
    int words_sent = 0;

    double_ended_queue_with_search DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_count      (m_count),
        .m_head_value (m_head_value),
        .m_tail_value (m_tail_value),
        .m_is_empty   (m_is_empty)
    );

    // Free-running 100 MHz clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watch both channels; the input is noted before the result is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) deq_model.note_word(s_mode, s_value);
            if (m_valid && m_ready) begin
                deq_model.check_word('{m_status, m_found, m_position, m_count,
                                       m_head_value, m_tail_value, m_is_empty});
            end
        end
    end

    // Result side: stall a random number of cycles before taking each word.
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Hand one word to the block after a random gap and wait for acceptance.
    task send_word(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_mode  <= mode;
        s_value <= value;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Hold off the input until the block has returned every owed word.
    task wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (deq_model.outstanding() != 0);
    endtask

    // Values biased toward the extremes and toward a few small repeats.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return VALUE_W'($urandom_range(0, 3));
            3: return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 2));
            default: return $urandom;
        endcase
    endfunction

    // Mostly values held in the deque, so that searches hit.
    function automatic logic [VALUE_W-1:0] pick_search_value();
        if (deq_model.fill > 0 && $urandom_range(0, 3) != 0)
            return deq_model.entry_at($urandom_range(0, deq_model.fill - 1));
        return pick_value();
    endfunction

    initial begin
        int random_sent;
        int next_break;
        int kind;
        int run;
        logic [MODE_W-1:0] mode;

        s_valid <= 1'b0;
        s_mode  <= MODE_PUSH_FRONT;
        s_value <= '0;
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: empty pops and search, spare modes, extreme values,
        // duplicate match, popping the last entry, and clear.
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_SEARCH, 32'h0);
        send_word(MODE_SPARE_6, 32'h0);
        send_word(MODE_SPARE_7, 32'hFFFF_FFFF);
        send_word(MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_word(MODE_PUSH_FRONT, 32'h8000_0000);
        send_word(MODE_SEARCH, 32'h8000_0000);
        send_word(MODE_SEARCH, 32'h7FFF_FFFF);
        send_word(MODE_SEARCH, 32'h0);
        send_word(MODE_PUSH_BACK, 32'h8000_0000);
        send_word(MODE_SEARCH, 32'h8000_0000);
        send_word(MODE_SPARE_6, 32'h1234_5678);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_FRONT, 32'hFFFF_FFFF);
        send_word(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(MODE_PUSH_BACK, 32'h0);
        send_word(MODE_CLEAR, 32'h5555_AAAA);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_SEARCH, 32'hFFFF_FFFF);
        wait_drained();

        // Start the random part by filling the deque past full.
        random_sent = 0;
        for (int i = 0; i < DEPTH_DEF + 2; i++) begin
            send_word(MODE_PUSH_BACK, pick_value());
            random_sent++;
        end
        next_break = PHASE_WORDS;

        // Random runs of pushes, pops and searches, with some clears and noise.
        while (random_sent < RANDOM_WORDS) begin
            if (random_sent >= next_break) begin
                wait_drained();
                no_idle = ($urandom_range(0, 3) == 0);
                next_break += PHASE_WORDS;
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: run = $urandom_range(1, 20);
                3, 4:    run = $urandom_range(1, 20);
                5, 6, 7: run = $urandom_range(1, 6);
                8:       run = 1;
                default: run = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < run; i++) begin
                case (kind)
                    0, 1, 2: begin
                        mode = ($urandom_range(0, 1) != 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                        send_word(mode, pick_value());
                    end
                    3, 4: begin
                        mode = ($urandom_range(0, 1) != 0) ? MODE_POP_BACK : MODE_POP_FRONT;
                        send_word(mode, $urandom);
                    end
                    5, 6, 7: send_word(MODE_SEARCH, pick_search_value());
                    8: begin
                        case ($urandom_range(0, 2))
                            0: mode = MODE_CLEAR;
                            1: mode = MODE_SPARE_6;
                            default: mode = MODE_SPARE_7;
                        endcase
                        send_word(mode, $urandom);
                    end
                    default: send_word(MODE_W'($urandom_range(0, 7)), pick_value());
                endcase
            end
            random_sent += run;
        end

        // Let the last results come out, then give stray words time to show.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (deq_model.outstanding() != 0)
            deq_model.report_mismatch("results never returned", 0, deq_model.outstanding());

        $display("Sent %0d words and checked %0d results; deepest fill was %0d of %0d.",
                 words_sent, deq_model.words_checked, deq_model.peak_fill, DEPTH_DEF);
        $display("Pushes refused as full: %0d, pops refused as empty: %0d, search hits: %0d.",
                 deq_model.full_pushes, deq_model.empty_pops, deq_model.search_hits);
        if (deq_model.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("Run timed out with %0d results still owed.", deq_model.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_datapath.sv
hdl/double_ended_queue_with_search.sv
sim/double_ended_queue_with_search_tb.sv
